>>> sv/edge_function_triangle_raster_assert.svh
// assertion macros for the triangle rasteriser
`ifndef EDGE_FUNCTION_TRIANGLE_RASTER_ASSERT_SVH
`define EDGE_FUNCTION_TRIANGLE_RASTER_ASSERT_SVH

`ifndef SYNTH

`define EFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define EFR_ASSERT_SAME(lbl, ante, cons, msg)

`define EFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/efr_pkg.sv
// shared constants and register codes for the triangle rasteriser
package efr_pkg;

  localparam int MAX_FRAME_DIM         = 4096;
  localparam int FRACTION_BITS_DEFAULT = 4;

  localparam int CW     = $clog2(MAX_FRAME_DIM);
  localparam int FDW    = 13;
  localparam int VW     = 16;
  localparam int CFG_DW = 16;
  localparam int CFG_IW = 3;

  localparam int FRAME_W_RESET = 640;
  localparam int FRAME_H_RESET = 480;

  typedef enum logic [CFG_IW-1:0] {
    REG_V0X     = 3'd0,
    REG_V0Y     = 3'd1,
    REG_V1X     = 3'd2,
    REG_V1Y     = 3'd3,
    REG_V2X     = 3'd4,
    REG_V2Y     = 3'd5,
    REG_FRAME_W = 3'd6,
    REG_FRAME_H = 3'd7
  } reg_idx_t;

endpackage

>>> sv/efr_in_if.sv
// command channel carrying the restart word
interface efr_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> sv/efr_out_if.sv
// pixel channel carrying one visited pixel, or an idle mark, per word
interface efr_out_if import efr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic          covered;
  logic          last_pixel;
  logic          idle;

  modport source (output valid, output pixel_x, output pixel_y, output covered,
                  output last_pixel, output idle, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input covered,
                  input last_pixel, input idle, output ready);
endinterface

>>> sv/edge_function_triangle_raster.sv
// edge function triangle rasteriser with bounding box walk
// a command word passes the input, walk step, edge product and output registers to its pixel word
// throughput: one command word, and one pixel, per cycle when the sink keeps ready high
// the walk step, the edge products and the sign compare each take one pipeline stage
// vertex and frame values feed a derived register stage, so a command is held off in the
// cycle of a configuration write; synchronous reset empties the pipeline and ends any walk
`include "edge_function_triangle_raster_assert.svh"

module edge_function_triangle_raster import efr_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  efr_in_if.sink            cmd,
  efr_out_if.source         pix
);

  localparam int EW  = VW + 2;
  localparam int VDW = VW + 1;
  localparam int DVW = VW + 2;
  localparam int AMW = 2 * VDW;
  localparam int PW  = CW + FRACTION_BITS + 2;
  localparam int XW  = ((PW > VW + 1) ? PW : VW + 1) + 1;
  localparam int MW  = XW + DVW;

  localparam logic signed [EW-1:0] ROUND_UP = EW'((1 << FRACTION_BITS) - 1);
  localparam int EA [3] = '{1, 2, 0};
  localparam int EB [3] = '{2, 0, 1};

  function automatic logic signed [VW-1:0] min3(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [VW-1:0] max3(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  function automatic logic signed [EW-1:0] floor_px(input logic signed [VW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    return e >>> FRACTION_BITS;
  endfunction

  function automatic logic signed [EW-1:0] ceil_px(input logic signed [VW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v) + ROUND_UP;
    return e >>> FRACTION_BITS;
  endfunction

  // configuration registers
  logic signed [VW-1:0] vtx_x [3];
  logic signed [VW-1:0] vtx_y [3];
  logic [FDW-1:0]       frame_w;
  logic [FDW-1:0]       frame_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vtx_x[i] <= '0;
        vtx_y[i] <= '0;
      end
      frame_w <= FDW'(FRAME_W_RESET);
      frame_h <= FDW'(FRAME_H_RESET);
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_V0X:     vtx_x[0] <= cfg_data[VW-1:0];
        REG_V0Y:     vtx_y[0] <= cfg_data[VW-1:0];
        REG_V1X:     vtx_x[1] <= cfg_data[VW-1:0];
        REG_V1Y:     vtx_y[1] <= cfg_data[VW-1:0];
        REG_V2X:     vtx_x[2] <= cfg_data[VW-1:0];
        REG_V2Y:     vtx_y[2] <= cfg_data[VW-1:0];
        REG_FRAME_W: frame_w <= cfg_data[FDW-1:0];
        REG_FRAME_H: frame_h <= cfg_data[FDW-1:0];
        default: ;
      endcase
    end
  end

  // derived values: clamped box, edge deltas, area products
  logic [FDW-1:0]        w_clamp, h_clamp;
  logic signed [EW-1:0]  wm1, hm1;
  logic signed [EW-1:0]  l_c, r_c, t_c, b_c;
  logic signed [VDW-1:0] ax20, ay10, ay20, ax10;
  logic signed [AMW-1:0] area_p_next, area_q_next;

  logic signed [EW-1:0]  lim_left, lim_right, lim_top, lim_bottom;
  logic signed [VDW-1:0] edge_dx [3];
  logic signed [VDW-1:0] edge_dy [3];
  logic signed [AMW-1:0] area_p, area_q;

  always_comb begin
    w_clamp = (frame_w > FDW'(MAX_FRAME_DIM)) ? FDW'(MAX_FRAME_DIM) : frame_w;
    h_clamp = (frame_h > FDW'(MAX_FRAME_DIM)) ? FDW'(MAX_FRAME_DIM) : frame_h;
    wm1 = $signed(EW'(w_clamp)) - EW'(1);
    hm1 = $signed(EW'(h_clamp)) - EW'(1);
    l_c = floor_px(min3(vtx_x[0], vtx_x[1], vtx_x[2]));
    r_c = ceil_px(max3(vtx_x[0], vtx_x[1], vtx_x[2]));
    t_c = floor_px(min3(vtx_y[0], vtx_y[1], vtx_y[2]));
    b_c = ceil_px(max3(vtx_y[0], vtx_y[1], vtx_y[2]));
    if (l_c < 0) l_c = '0;
    if (t_c < 0) t_c = '0;
    if (r_c > wm1) r_c = wm1;
    if (b_c > hm1) b_c = hm1;
    ax20 = VDW'(vtx_x[2]) - VDW'(vtx_x[0]);
    ay10 = VDW'(vtx_y[1]) - VDW'(vtx_y[0]);
    ay20 = VDW'(vtx_y[2]) - VDW'(vtx_y[0]);
    ax10 = VDW'(vtx_x[1]) - VDW'(vtx_x[0]);
    area_p_next = ax20 * ay10;
    area_q_next = ay20 * ax10;
  end

  always_ff @(posedge clk) begin
    lim_left   <= l_c;
    lim_right  <= r_c;
    lim_top    <= t_c;
    lim_bottom <= b_c;
    area_p     <= area_p_next;
    area_q     <= area_q_next;
    for (int e = 0; e < 3; e++) begin
      edge_dx[e] <= VDW'(vtx_x[EB[e]]) - VDW'(vtx_x[EA[e]]);
      edge_dy[e] <= VDW'(vtx_y[EB[e]]) - VDW'(vtx_y[EA[e]]);
    end
  end

  // pipeline handshake
  logic v0, v1, v2, v3;
  logic en0, en1, en2, en3;
  logic take, step;

  assign en3       = !v3 || pix.ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign en0       = !v0 || en1;
  assign cmd.ready = en0 && !cfg_wr_en && !rst;
  assign take      = cmd.valid && cmd.ready;
  assign step      = en1 && v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= take;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // input register
  logic s0_restart;

  always_ff @(posedge clk) begin
    if (en0) s0_restart <= cmd.restart;
  end

  // walk step
  logic [CW-1:0] cursor_x, cursor_y, box_left, box_right, box_bottom;
  logic          walk_active;
  logic [CW-1:0] cursor_x_next, cursor_y_next;
  logic [CW-1:0] box_left_next, box_right_next, box_bottom_next;
  logic          walk_active_next;

  logic          degenerate, box_empty, start_ok, act;
  logic [CW-1:0] cur_x, cur_y, cur_left, cur_right, cur_bottom;
  logic [CW-1:0] s1_x_next, s1_y_next;
  logic          s1_last_next, s1_idle_next;

  always_comb begin
    degenerate = (area_p == area_q);
    box_empty  = (lim_left > lim_right) || (lim_top > lim_bottom);
    start_ok   = !degenerate && !box_empty;

    cur_x      = s0_restart ? lim_left[CW-1:0]   : cursor_x;
    cur_y      = s0_restart ? lim_top[CW-1:0]    : cursor_y;
    cur_left   = s0_restart ? lim_left[CW-1:0]   : box_left;
    cur_right  = s0_restart ? lim_right[CW-1:0]  : box_right;
    cur_bottom = s0_restart ? lim_bottom[CW-1:0] : box_bottom;
    act        = s0_restart ? start_ok : walk_active;

    cursor_x_next    = cursor_x;
    cursor_y_next    = cursor_y;
    box_left_next    = box_left;
    box_right_next   = box_right;
    box_bottom_next  = box_bottom;
    walk_active_next = 1'b0;

    s1_x_next    = '0;
    s1_y_next    = '0;
    s1_last_next = 1'b0;
    s1_idle_next = 1'b1;

    if (act) begin
      s1_x_next       = cur_x;
      s1_y_next       = cur_y;
      s1_last_next    = (cur_x == cur_right) && (cur_y == cur_bottom);
      s1_idle_next    = 1'b0;
      box_left_next   = cur_left;
      box_right_next  = cur_right;
      box_bottom_next = cur_bottom;
      if (s1_last_next) begin
        walk_active_next = 1'b0;
      end else if (cur_x == cur_right) begin
        walk_active_next = 1'b1;
        cursor_x_next    = cur_left;
        cursor_y_next    = cur_y + CW'(1);
      end else begin
        walk_active_next = 1'b1;
        cursor_x_next    = cur_x + CW'(1);
        cursor_y_next    = cur_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      box_left    <= '0;
      box_right   <= '0;
      box_bottom  <= '0;
      walk_active <= 1'b0;
    end else if (step) begin
      cursor_x    <= cursor_x_next;
      cursor_y    <= cursor_y_next;
      box_left    <= box_left_next;
      box_right   <= box_right_next;
      box_bottom  <= box_bottom_next;
      walk_active <= walk_active_next;
    end
  end

  logic [CW-1:0] s1_x, s1_y;
  logic          s1_last, s1_idle;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_x    <= s1_x_next;
      s1_y    <= s1_y_next;
      s1_last <= s1_last_next;
      s1_idle <= s1_idle_next;
    end
  end

  // edge products at the pixel centre, half-lsb units
  logic signed [XW-1:0]  px, py;
  logic signed [XW-1:0]  dxp [3];
  logic signed [XW-1:0]  dyp [3];
  logic signed [DVW-1:0] dx2 [3];
  logic signed [DVW-1:0] dy2 [3];
  logic signed [MW-1:0]  prod_p_next [3];
  logic signed [MW-1:0]  prod_q_next [3];

  always_comb begin
    px = $signed(XW'({s1_x, 1'b1}) << FRACTION_BITS);
    py = $signed(XW'({s1_y, 1'b1}) << FRACTION_BITS);
    for (int e = 0; e < 3; e++) begin
      dxp[e] = px - XW'($signed({vtx_x[EA[e]], 1'b0}));
      dyp[e] = py - XW'($signed({vtx_y[EA[e]], 1'b0}));
      dx2[e] = $signed({edge_dx[e], 1'b0});
      dy2[e] = $signed({edge_dy[e], 1'b0});
      prod_p_next[e] = dxp[e] * dy2[e];
      prod_q_next[e] = dyp[e] * dx2[e];
    end
  end

  logic signed [MW-1:0] prod_p [3];
  logic signed [MW-1:0] prod_q [3];
  logic [CW-1:0]        s2_x, s2_y;
  logic                 s2_last, s2_idle;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int e = 0; e < 3; e++) begin
        prod_p[e] <= prod_p_next[e];
        prod_q[e] <= prod_q_next[e];
      end
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_last <= s1_last;
      s2_idle <= s1_idle;
    end
  end

  // sign test and output register
  logic any_neg, any_pos, covered_next;

  always_comb begin
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (int e = 0; e < 3; e++) begin
      any_neg = any_neg || (prod_p[e] < prod_q[e]);
      any_pos = any_pos || (prod_p[e] > prod_q[e]);
    end
    covered_next = !s2_idle && !(any_neg && any_pos);
  end

  logic [CW-1:0] o_x, o_y;
  logic          o_covered, o_last, o_idle;

  always_ff @(posedge clk) begin
    if (en3) begin
      o_x       <= s2_x;
      o_y       <= s2_y;
      o_covered <= covered_next;
      o_last    <= s2_last;
      o_idle    <= s2_idle;
    end
  end

  assign pix.valid      = v3;
  assign pix.pixel_x    = o_x;
  assign pix.pixel_y    = o_y;
  assign pix.covered    = o_covered;
  assign pix.last_pixel = o_last;
  assign pix.idle       = o_idle;

  `EFR_ASSERT_NEXT(a_last_ends_walk, step && s1_last_next, !walk_active, "walk still active after last pixel")
  `EFR_ASSERT_NEXT(a_degen_no_walk, step && s0_restart && degenerate, !walk_active, "walk started on a degenerate triangle")
  `EFR_ASSERT_SAME(a_cursor_in_box, walk_active, (cursor_x >= box_left) && (cursor_x <= box_right) && (cursor_y <= box_bottom), "cursor outside the box")
  `EFR_ASSERT_SAME(a_idle_word_clear, pix.valid && pix.idle, (pix.pixel_x == '0) && (pix.pixel_y == '0) && !pix.covered && !pix.last_pixel, "idle word carries pixel data")

endmodule

>>> verif/tb_edge_function_triangle_raster.sv
// self-checking testbench for the edge function triangle rasteriser
module tb_edge_function_triangle_raster;
  import efr_pkg::*;

  localparam int FB          = FRACTION_BITS_DEFAULT;
  localparam int ITEMS       = 1250;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic          covered;
    logic          last_pixel;
    logic          idle;
  } pixel_word_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  efr_in_if  cmd ();
  efr_out_if pix ();

  edge_function_triangle_raster DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .pix       (pix)
  );

  logic signed [VW-1:0] vert_sh [6];
  logic [FDW-1:0]       frame_w_sh;
  logic [FDW-1:0]       frame_h_sh;
  logic [CW-1:0]        cur_x, cur_y, box_l, box_r, box_b;
  bit                   walking;

  bit          restart_queue [$];
  pixel_word_t pixel_expect_q [$];

  int src_idle_pct;
  int sink_stall_pct;
  bit hold_off;
  int errors = 0;
  int items;
  int quiet_cycles;

  int src_idle   [4] = '{0, 65, 0, 24};
  int sink_stall [4] = '{0, 0, 65, 24};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint edge_value(input longint ax, ay, bx, by, cx, cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  function automatic bit clamped_box(output longint l, r, t, b);
    longint xs [3];
    longint ys [3];
    longint mnx, mxx, mny, mxy, w, h;
    int     i;
    for (i = 0; i < 3; i++) begin
      xs[i] = longint'(vert_sh[2*i]);
      ys[i] = longint'(vert_sh[2*i+1]);
    end
    mnx = xs[0]; mxx = xs[0]; mny = ys[0]; mxy = ys[0];
    for (i = 1; i < 3; i++) begin
      if (xs[i] < mnx) mnx = xs[i];
      if (xs[i] > mxx) mxx = xs[i];
      if (ys[i] < mny) mny = ys[i];
      if (ys[i] > mxy) mxy = ys[i];
    end
    w = frame_w_sh;
    h = frame_h_sh;
    if (w > MAX_FRAME_DIM) w = MAX_FRAME_DIM;
    if (h > MAX_FRAME_DIM) h = MAX_FRAME_DIM;
    l = mnx >>> FB;
    r = -((-mxx) >>> FB);
    t = mny >>> FB;
    b = -((-mxy) >>> FB);
    if (l < 0) l = 0;
    if (r > w - 1) r = w - 1;
    if (t < 0) t = 0;
    if (b > h - 1) b = h - 1;
    return edge_value(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]) != 0 && l <= r && t <= b;
  endfunction

  function automatic int box_pixel_count();
    longint l, r, t, b;
    if (!clamped_box(l, r, t, b)) return 0;
    return int'((r - l + 1) * (b - t + 1));
  endfunction

  // edge functions at the pixel centre, in half-lsb units
  function automatic bit centre_covered(logic [CW-1:0] x, logic [CW-1:0] y);
    longint vx [3];
    longint vy [3];
    longint px, py, w0, w1, w2;
    bit     neg, pos;
    int     i;
    for (i = 0; i < 3; i++) begin
      vx[i] = 2 * longint'(vert_sh[2*i]);
      vy[i] = 2 * longint'(vert_sh[2*i+1]);
    end
    px = longint'(x) * (2 << FB) + (1 << FB);
    py = longint'(y) * (2 << FB) + (1 << FB);
    w0 = edge_value(vx[1], vy[1], vx[2], vy[2], px, py);
    w1 = edge_value(vx[2], vy[2], vx[0], vy[0], px, py);
    w2 = edge_value(vx[0], vy[0], vx[1], vy[1], px, py);
    neg = (w0 < 0) || (w1 < 0) || (w2 < 0);
    pos = (w0 > 0) || (w1 > 0) || (w2 > 0);
    return !(neg && pos);
  endfunction

  function automatic pixel_word_t raster_step(bit restart);
    pixel_word_t res;
    longint      l, r, t, b;
    bit          fin;
    res = '0;
    res.idle = 1'b1;
    if (restart) begin
      walking = 1'b0;
      if (!clamped_box(l, r, t, b)) return res;
      box_l   = l[CW-1:0];
      box_r   = r[CW-1:0];
      box_b   = b[CW-1:0];
      cur_x   = l[CW-1:0];
      cur_y   = t[CW-1:0];
      walking = 1'b1;
    end
    if (!walking) return res;
    fin = (cur_x == box_r) && (cur_y == box_b);
    res.pixel_x    = cur_x;
    res.pixel_y    = cur_y;
    res.covered    = centre_covered(cur_x, cur_y);
    res.last_pixel = fin;
    res.idle       = 1'b0;
    if (fin) begin
      walking = 1'b0;
    end else if (cur_x == box_r) begin
      cur_x = box_l;
      cur_y = cur_y + 1'b1;
    end else begin
      cur_x = cur_x + 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid   <= 1'b0;
      cmd.restart <= 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      if (!hold_off && restart_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cmd.valid   <= 1'b1;
        cmd.restart <= restart_queue.pop_front();
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // pixel monitor and prediction
  always @(posedge clk) begin : monitor
    pixel_word_t got, want;
    if (rst) begin
      pix.ready <= 1'b0;
      cur_x   = '0;
      cur_y   = '0;
      box_l   = '0;
      box_r   = '0;
      box_b   = '0;
      walking = 1'b0;
    end else begin
      pix.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (pix.valid && pix.ready) begin
        got = {pix.pixel_x, pix.pixel_y, pix.covered, pix.last_pixel, pix.idle};
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, got %p", $time, got);
          errors++;
        end else begin
          want = pixel_expect_q.pop_front();
          check_field("pixel_x", want.pixel_x, got.pixel_x);
          check_field("pixel_y", want.pixel_y, got.pixel_y);
          check_field("covered", want.covered, got.covered);
          check_field("last_pixel", want.last_pixel, got.last_pixel);
          check_field("idle", want.idle, got.idle);
        end
      end
      if (cmd.valid && cmd.ready) pixel_expect_q.push_back(raster_step(cmd.restart));
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (pix.valid && pix.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL edge_function_triangle_raster");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_reg(reg_idx_t idx, longint val);
    if (idx != REG_FRAME_W && idx != REG_FRAME_H) begin
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
    end
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DW-1:0];
    case (idx)
      REG_FRAME_W: frame_w_sh = val[FDW-1:0];
      REG_FRAME_H: frame_h_sh = val[FDW-1:0];
      default:     vert_sh[idx] = val[VW-1:0];
    endcase
  endtask

  task automatic close_cfg();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (restart_queue.size() != 0 || cmd.valid || pixel_expect_q.size() != 0);
  endtask

  task automatic queue_words(bit rs, int count);
    repeat (count) restart_queue.push_back(rs);
    items += count;
  endtask

  task automatic queue_full_walk(int extra);
    int n;
    n = box_pixel_count();
    queue_words(1'b1, 1);
    queue_words(1'b0, (n > 0 ? n - 1 : 0) + extra);
  endtask

  task automatic pick_anchor(output longint cx, output longint cy);
    longint wx, wy;
    wx = frame_w_sh;
    wy = frame_h_sh;
    if (wx > 2047) wx = 2047;
    if (wy > 2047) wy = 2047;
    cx = longint'($urandom_range(0, int'(wx) + 6)) - 4;
    cy = longint'($urandom_range(0, int'(wy) + 6)) - 4;
  endtask

  task automatic write_triangle(longint cx, longint cy, int span);
    int i;
    for (i = 0; i < 3; i++) begin
      set_reg(reg_idx_t'(2*i), cx * 16 + longint'($urandom_range(0, span * 16)));
      set_reg(reg_idx_t'(2*i+1), cy * 16 + longint'($urandom_range(0, span * 16)));
    end
    close_cfg();
  endtask

  function automatic longint pick_dim();
    int s;
    s = $urandom_range(99);
    if (s < 52) return $urandom_range(8, 64);
    if (s < 66) return MAX_FRAME_DIM;
    if (s < 74) return 1;
    if (s < 77) return 0;
    if (s < 88) return $urandom_range(MAX_FRAME_DIM + 1, 8191);
    return $urandom_range(0, 65535);
  endfunction

  initial begin : stimulus
    int     ph, sel, target, n, k, span, i;
    longint cx, cy, dx, dy, m;
    bit     pressure_done;

    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_V0X;
    cfg_data       = '0;
    hold_off       = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items          = 0;
    for (i = 0; i < 6; i++) vert_sh[i] = '0;
    frame_w_sh = FRAME_W_RESET;
    frame_h_sh = FRAME_H_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // advance with no walk, then restart on the zero-area reset triangle
    queue_words(1'b0, 1);
    queue_words(1'b1, 1);
    wait_drained();

    // vertices on pixel centres, so edge pixels count as inside
    set_reg(REG_V0X, 8);  set_reg(REG_V0Y, 8);
    set_reg(REG_V1X, 24); set_reg(REG_V1Y, 8);
    set_reg(REG_V2X, 8);  set_reg(REG_V2Y, 24);
    close_cfg();
    queue_words(1'b1, 1);
    queue_words(1'b0, 3);
    wait_drained();
    // vertex moved mid-walk, box stays
    set_reg(REG_V1X, 40);
    close_cfg();
    queue_words(1'b0, 6);
    wait_drained();

    // zero frame width
    set_reg(REG_FRAME_W, 0);
    close_cfg();
    queue_words(1'b1, 1);
    wait_drained();

    // triangle wholly off the frame
    set_reg(REG_FRAME_W, FRAME_W_RESET);
    set_reg(REG_V0X, -64); set_reg(REG_V0Y, -64);
    set_reg(REG_V1X, -32); set_reg(REG_V1Y, -64);
    set_reg(REG_V2X, -64); set_reg(REG_V2Y, -32);
    close_cfg();
    queue_words(1'b1, 1);
    wait_drained();

    // extreme vertices in an oversized frame
    set_reg(REG_FRAME_W, 8191);
    set_reg(REG_FRAME_H, MAX_FRAME_DIM);
    set_reg(REG_V0X, -32768); set_reg(REG_V0Y, -32768);
    set_reg(REG_V1X, 32767);  set_reg(REG_V1Y, -32768);
    set_reg(REG_V2X, -32768); set_reg(REG_V2Y, 32767);
    close_cfg();
    queue_words(1'b1, 1);
    queue_words(1'b0, 2);
    wait_drained();

    // single pixel frame
    set_reg(REG_FRAME_W, 1);
    set_reg(REG_FRAME_H, 1);
    close_cfg();
    queue_words(1'b1, 1);
    queue_words(1'b0, 1);
    wait_drained();

    set_reg(REG_FRAME_W, FRAME_W_RESET);
    set_reg(REG_FRAME_H, FRAME_H_RESET);
    close_cfg();

    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_idle[ph];
      sink_stall_pct = sink_stall[ph];
      target         = items + ITEMS / 4;
      pressure_done  = 1'b0;
      while (items < target) begin
        if (!pressure_done && items > target - ITEMS / 8) begin
          hold_off = 1'b1;
          do @(negedge clk);
          while (cmd.valid || pixel_expect_q.size() != 0);
          hold_off      = 1'b0;
          pressure_done = 1'b1;
        end
        sel  = $urandom_range(99);
        span = $urandom_range(1, 6);
        if (sel < 90) begin
          wait_drained();
          pick_anchor(cx, cy);
        end
        if (sel < 58) begin
          write_triangle(cx, cy, span);
          queue_full_walk($urandom_range(0, 2));
        end else if (sel < 66) begin
          write_triangle(cx, cy, span);
          n = box_pixel_count();
          if (n < 3) begin
            queue_full_walk(1);
          end else begin
            k = $urandom_range(1, n - 2);
            queue_words(1'b1, 1);
            queue_words(1'b0, k);
            wait_drained();
            write_triangle(cx, cy, span);
            queue_words(1'b0, n - k);
          end
        end else if (sel < 74) begin
          // walk cut short by a fresh restart
          write_triangle(cx, cy, span);
          n = box_pixel_count();
          queue_words(1'b1, 1);
          queue_words(1'b0, $urandom_range(0, n));
          queue_full_walk(0);
        end else if (sel < 82) begin
          // collinear or coincident vertices
          dx = longint'($urandom_range(0, 40)) - 20;
          dy = longint'($urandom_range(0, 40)) - 20;
          m  = longint'($urandom_range(0, 5)) - 2;
          set_reg(REG_V0X, cx * 16);
          set_reg(REG_V0Y, cy * 16);
          set_reg(REG_V1X, cx * 16 + dx);
          set_reg(REG_V1Y, cy * 16 + dy);
          set_reg(REG_V2X, cx * 16 + m * dx);
          set_reg(REG_V2Y, cy * 16 + m * dy);
          close_cfg();
          queue_words(1'b1, 1);
          queue_words(1'b0, $urandom_range(0, 2));
        end else if (sel < 90) begin
          for (i = 0; i < 6; i++)
            set_reg(reg_idx_t'(i), longint'($urandom_range(0, 65535)) - 32768);
          close_cfg();
          repeat (12) queue_words($urandom_range(99) < 25, 1);
        end else begin
          wait_drained();
          set_reg(REG_FRAME_W, pick_dim());
          set_reg(REG_FRAME_H, pick_dim());
          close_cfg();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pixel_expect_q.size() == 0) begin
      $display("PASS edge_function_triangle_raster");
    end else begin
      $display("FAIL edge_function_triangle_raster");
    end
    $finish;
  end

endmodule

>>> edge_function_triangle_raster.f
+incdir+sv
sv/efr_pkg.sv
sv/efr_in_if.sv
sv/efr_out_if.sv
sv/edge_function_triangle_raster.sv
verif/tb_edge_function_triangle_raster.sv
